// ===== rtl/lpp_pkg.sv =====
// Package: request/response types, parse phases and protocol constants for the peer message parser.
`timescale 1ns / 1ps
package lpp_pkg;

   localparam int SEG_LEN_PORT_W = 16;
   localparam int HS_CMP_W       = SEG_LEN_PORT_W + 1;

   typedef struct packed {
      logic [7:0]                data_byte;
      logic                      segment_start;
      logic [SEG_LEN_PORT_W-1:0] segment_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [7:0]  message_code;
      logic [1:0]  status;
      logic [31:0] body_length;
      logic [31:0] piece_number;
      logic [31:0] piece_offset;
      logic [31:0] piece_bytes;
      logic [34:0] bits_set;
      logic [63:0] content_size;
      logic [31:0] peer_suffix;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_BOUNDARY  = 3'd0,
      PH_LENGTH    = 3'd1,
      PH_ID        = 3'd2,
      PH_BODY      = 3'd3,
      PH_HANDSHAKE = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_HANDSHAKE = 2'd0;
   localparam logic [1:0] KIND_KEEPALIVE = 2'd1;
   localparam logic [1:0] KIND_REGULAR   = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_LENGTH  = 2'd1;
   localparam logic [1:0] ST_UNKNOWN_ID  = 2'd2;

   localparam logic [7:0] MSG_NOT_INTERESTED = 8'd3;
   localparam logic [7:0] MSG_HAVE           = 8'd4;
   localparam logic [7:0] MSG_BITFIELD       = 8'd5;
   localparam logic [7:0] MSG_REQUEST        = 8'd6;
   localparam logic [7:0] MSG_PIECE          = 8'd7;
   localparam logic [7:0] MSG_CANCEL         = 8'd8;
   localparam logic [7:0] MSG_EXTENDED       = 8'd20;

   localparam logic [31:0] LEN_NO_PAYLOAD = 32'd1;
   localparam logic [31:0] LEN_HAVE       = 32'd5;
   localparam logic [31:0] LEN_REQUEST    = 32'd13;
   localparam logic [31:0] LEN_PIECE_HDR  = 32'd9;

   localparam logic [31:0] PREFIX_BYTES   = 32'd4;
   localparam logic [31:0] INDEX_END      = 32'd4;
   localparam logic [31:0] OFFSET_END     = 32'd8;
   localparam logic [31:0] SIZE_END       = 32'd12;

   // handshake: name, 8 size bytes, 32 hash bytes, 16 peer id bytes, 4 suffix bytes
   localparam logic [31:0] HS_SIZE_BYTES   = 32'd8;
   localparam logic [31:0] HS_SUFFIX_START = 32'd56;
   localparam logic [31:0] HS_FIXED        = 32'd60;
   localparam logic [HS_CMP_W-1:0] HS_NAME_BASE = HS_CMP_W'(61);

   function automatic logic [3:0] popcount8(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(b[i]);
      end
      return n;
   endfunction

endpackage

// ===== rtl/lpp_parser.sv =====
// Byte-at-a-time parse state machine: updates counters and accumulators, forms one result.
`timescale 1ns / 1ps
module lpp_parser #(
   parameter int SEG_LEN_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  lpp_pkg::req_type req_data,
   output logic             res_valid,
   output lpp_pkg::rsp_type res_data
);

   localparam int HeldW = (SEG_LEN_BITS < lpp_pkg::SEG_LEN_PORT_W) ?
                          SEG_LEN_BITS : lpp_pkg::SEG_LEN_PORT_W;

   lpp_pkg::phase_type phase_ff, phase_in, live_phase;
   logic        discard_ff, discard_in, live_discard;
   logic [31:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [7:0]  code_ff, code_in;
   logic [31:0] index_ff, index_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] size_ff, size_in;
   logic [34:0] ones_ff, ones_in;
   logic [63:0] wide_ff, wide_in;
   logic [31:0] suffix_ff, suffix_in;
   logic [7:0]  name_len_ff, name_len_in;

   logic [7:0]                    b;
   logic                          sos;
   logic [HeldW-1:0]              seg_len;
   logic [lpp_pkg::HS_CMP_W-1:0]  hs_total;
   logic [lpp_pkg::HS_CMP_W-1:0]  name_plus;
   logic [31:0]                   count_inc;
   logic [31:0]                   nl32;
   logic [31:0]                   len_shift;
   logic                          bad;
   logic [1:0]                    id_status;

   assign b         = req_data.data_byte;
   assign sos       = req_data.segment_start;
   assign seg_len   = req_data.segment_length[HeldW-1:0];
   assign hs_total  = lpp_pkg::HS_CMP_W'(seg_len);
   assign name_plus = lpp_pkg::HS_CMP_W'(b) + lpp_pkg::HS_NAME_BASE;
   assign count_inc = count_ff + 32'd1;
   assign nl32      = 32'(name_len_ff);
   assign len_shift = {length_ff[23:0], b};

   always_comb begin
      phase_in     = phase_ff;
      discard_in   = discard_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      code_in      = code_ff;
      index_in     = index_ff;
      offset_in    = offset_ff;
      size_in      = size_ff;
      ones_in      = ones_ff;
      wide_in      = wide_ff;
      suffix_in    = suffix_ff;
      name_len_in  = name_len_ff;
      live_phase   = phase_ff;
      live_discard = discard_ff;
      bad          = 1'b0;
      id_status    = lpp_pkg::ST_OK;
      res_valid    = 1'b0;
      res_data     = '0;
      if (accept) begin
         if (sos && discard_ff) begin
            live_discard = 1'b0;
            live_phase   = lpp_pkg::PH_BOUNDARY;
         end
         discard_in = live_discard;
         phase_in   = live_phase;
         if (!live_discard) begin
            case (live_phase)
               lpp_pkg::PH_BOUNDARY: begin
                  if (sos && (name_plus == hs_total)) begin
                     name_len_in = b;
                     count_in    = '0;
                     wide_in     = '0;
                     suffix_in   = '0;
                     phase_in    = lpp_pkg::PH_HANDSHAKE;
                  end else begin
                     length_in = 32'(b);
                     count_in  = 32'd1;
                     phase_in  = lpp_pkg::PH_LENGTH;
                  end
               end
               lpp_pkg::PH_LENGTH: begin
                  length_in = len_shift;
                  count_in  = count_inc;
                  if (count_inc == lpp_pkg::PREFIX_BYTES) begin
                     if (len_shift == 32'd0) begin
                        phase_in            = lpp_pkg::PH_BOUNDARY;
                        res_valid           = 1'b1;
                        res_data.frame_kind = lpp_pkg::KIND_KEEPALIVE;
                     end else begin
                        phase_in = lpp_pkg::PH_ID;
                     end
                  end
               end
               lpp_pkg::PH_ID: begin
                  code_in   = b;
                  index_in  = '0;
                  offset_in = '0;
                  size_in   = '0;
                  ones_in   = '0;
                  count_in  = '0;
                  if (b <= lpp_pkg::MSG_NOT_INTERESTED) begin
                     bad = (length_ff != lpp_pkg::LEN_NO_PAYLOAD);
                  end else if (b == lpp_pkg::MSG_HAVE) begin
                     bad = (length_ff != lpp_pkg::LEN_HAVE);
                  end else if (b == lpp_pkg::MSG_REQUEST || b == lpp_pkg::MSG_CANCEL) begin
                     bad = (length_ff != lpp_pkg::LEN_REQUEST);
                  end else if (b == lpp_pkg::MSG_PIECE) begin
                     bad = (length_ff <= lpp_pkg::LEN_PIECE_HDR);
                     if (!bad) begin
                        size_in = length_ff - lpp_pkg::LEN_PIECE_HDR;
                     end
                  end else if (b != lpp_pkg::MSG_BITFIELD && b != lpp_pkg::MSG_EXTENDED) begin
                     id_status = lpp_pkg::ST_UNKNOWN_ID;
                  end
                  if (bad) begin
                     discard_in = 1'b1;
                     phase_in   = lpp_pkg::PH_BOUNDARY;
                     res_valid  = 1'b1;
                     res_data.frame_kind   = lpp_pkg::KIND_REGULAR;
                     res_data.message_code = b;
                     res_data.status       = lpp_pkg::ST_BAD_LENGTH;
                     res_data.body_length  = length_ff;
                  end else if (length_ff == lpp_pkg::LEN_NO_PAYLOAD) begin
                     phase_in  = lpp_pkg::PH_BOUNDARY;
                     res_valid = 1'b1;
                     res_data.frame_kind   = lpp_pkg::KIND_REGULAR;
                     res_data.message_code = b;
                     res_data.status       = id_status;
                     res_data.body_length  = length_ff;
                     res_data.piece_bytes  = size_in;
                  end else begin
                     phase_in = lpp_pkg::PH_BODY;
                  end
               end
               lpp_pkg::PH_BODY: begin
                  if (code_ff == lpp_pkg::MSG_BITFIELD) begin
                     ones_in = ones_ff + 35'(lpp_pkg::popcount8(b));
                  end else if (code_ff inside {lpp_pkg::MSG_HAVE, lpp_pkg::MSG_REQUEST,
                                               lpp_pkg::MSG_PIECE, lpp_pkg::MSG_CANCEL}) begin
                     if (count_ff < lpp_pkg::INDEX_END) begin
                        index_in = {index_ff[23:0], b};
                     end else if (count_ff < lpp_pkg::OFFSET_END) begin
                        offset_in = {offset_ff[23:0], b};
                     end else if (count_ff < lpp_pkg::SIZE_END &&
                                  code_ff != lpp_pkg::MSG_PIECE) begin
                        size_in = {size_ff[23:0], b};
                     end
                  end
                  count_in = count_inc;
                  if (count_inc == (length_ff - 32'd1)) begin
                     phase_in  = lpp_pkg::PH_BOUNDARY;
                     res_valid = 1'b1;
                     res_data.frame_kind   = lpp_pkg::KIND_REGULAR;
                     res_data.message_code = code_ff;
                     res_data.status       = (code_ff <= lpp_pkg::MSG_CANCEL ||
                                              code_ff == lpp_pkg::MSG_EXTENDED) ?
                                             lpp_pkg::ST_OK : lpp_pkg::ST_UNKNOWN_ID;
                     res_data.body_length  = length_ff;
                     res_data.piece_number = index_in;
                     res_data.piece_offset = offset_in;
                     res_data.piece_bytes  = size_in;
                     res_data.bits_set     = ones_in;
                  end
               end
               lpp_pkg::PH_HANDSHAKE: begin
                  if (count_ff >= nl32 && count_ff < nl32 + lpp_pkg::HS_SIZE_BYTES) begin
                     wide_in = {wide_ff[55:0], b};
                  end else if (count_ff >= nl32 + lpp_pkg::HS_SUFFIX_START &&
                               count_ff < nl32 + lpp_pkg::HS_FIXED) begin
                     suffix_in = {suffix_ff[23:0], b};
                  end
                  count_in = count_inc;
                  if (count_inc == nl32 + lpp_pkg::HS_FIXED) begin
                     phase_in  = lpp_pkg::PH_BOUNDARY;
                     res_valid = 1'b1;
                     res_data.frame_kind   = lpp_pkg::KIND_HANDSHAKE;
                     res_data.content_size = wide_in;
                     res_data.peer_suffix  = suffix_in;
                  end
               end
               default: begin
                  phase_in = lpp_pkg::PH_BOUNDARY;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lpp_pkg::PH_BOUNDARY;
         discard_ff  <= 1'b0;
         count_ff    <= '0;
         length_ff   <= '0;
         code_ff     <= '0;
         index_ff    <= '0;
         offset_ff   <= '0;
         size_ff     <= '0;
         ones_ff     <= '0;
         wide_ff     <= '0;
         suffix_ff   <= '0;
         name_len_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         discard_ff  <= discard_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         code_ff     <= code_in;
         index_ff    <= index_in;
         offset_ff   <= offset_in;
         size_ff     <= size_in;
         ones_ff     <= ones_in;
         wide_ff     <= wide_in;
         suffix_ff   <= suffix_in;
         name_len_ff <= name_len_in;
      end
   end

endmodule

// ===== rtl/lpp_out_buf.sv =====
// Two-entry output register with skid stage for the response channel.
`timescale 1ns / 1ps
module lpp_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpp_pkg::rsp_type push_data,
   output logic             can_push,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpp_pkg::rsp_type rsp_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   lpp_pkg::rsp_type out_data_ff, out_data_in;
   lpp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign pop       = out_valid_ff && rsp_ready;
   assign can_push  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== rtl/length_prefixed_peer_message_parser_top.sv =====
// Top level of the length-prefixed peer message parser: parse stage plus response buffer.
//
//   channel   ports                          width     direction
//   request   req_valid/req_ready/req_data   25 bits   in
//   response  rsp_valid/rsp_ready/rsp_data   271 bits  out
//
// One byte is taken per cycle while req_ready is high. A response is registered in the
// output register, or the skid register while that holds one not yet accepted. The parse
// state and field accumulators update in the same edge that accepts the byte. Synchronous
// reset returns to a message boundary. req_ready drops only while both response registers
// are full, so a stalled rsp_ready costs two responses of slack before requests stall.
`timescale 1ns / 1ps
module length_prefixed_peer_message_parser_top #(
   parameter int SEG_LEN_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpp_pkg::rsp_type rsp_data
);

   logic             accept;
   logic             res_valid;
   lpp_pkg::rsp_type res_data;

   assign accept = req_valid && req_ready;

   lpp_parser #(
      .SEG_LEN_BITS(SEG_LEN_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .res_valid(res_valid),
      .res_data (res_data)
   );

   lpp_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res_data),
      .can_push (req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no response pending");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lpp_pkg::ST_OK |->
         rsp_data.frame_kind == lpp_pkg::KIND_REGULAR &&
         rsp_data.piece_number == 32'd0 && rsp_data.bits_set == 35'd0)
      else $error("error response carries field data");

   a_keepalive_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_kind == lpp_pkg::KIND_KEEPALIVE |->
         rsp_data.body_length == 32'd0 && rsp_data.message_code == 8'd0)
      else $error("keepalive with nonzero length or code");

   a_rsp_held_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule
